FILE: design/rlvd_pkg.sv
// Package for the run-length varint decoder.
// Holds widths, input codes, the count group limit and the result types.
// No dependencies; compile first.
package rlvd_pkg;

  // Maximum number of 7-bit count groups that are kept per run.
  localparam int MAX_GROUPS  = 4;
  // The accumulator holds 28 bits, so at most four groups ever fit.
  localparam int ACC_GROUPS  = 4;
  localparam int GROUP_LIMIT = (MAX_GROUPS > ACC_GROUPS) ? ACC_GROUPS : MAX_GROUPS;

  localparam int GROUP_BITS = 7;
  localparam int ACC_W      = 28;
  localparam int GIDX_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 29;
  localparam int RUN_BIAS   = 2;

  // Result queue depth and its pointer and fill count widths.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input item kinds.
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] run_byte;
    logic [LEN_W-1:0]  run_length;
    logic              count_overflow;
    logic              last;
  } rlvd_result_t;

  // Results produced by one accepted input item, in order.
  typedef struct packed {
    logic [1:0]   num;
    rlvd_result_t first;
    rlvd_result_t second;
  } rlvd_push_t;

endpackage

FILE: design/rlvd_if.sv
// Channel interfaces of the run-length varint decoder.
// Depends on rlvd_pkg for field widths.
interface rlvd_in_if import rlvd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

interface rlvd_out_if import rlvd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] run_byte;
  logic [LEN_W-1:0]  run_length;
  logic              count_overflow;
  logic              last;

  modport source (output valid, output run_byte, output run_length,
                  output count_overflow, output last, input ready);
  modport sink   (input valid, input run_byte, input run_length,
                  input count_overflow, input last, output ready);
endinterface

FILE: design/rlvd_core.sv
// Decoder state and per-byte update of the run-length varint decoder.
// Depends on rlvd_pkg; produces zero, one or two results per transfer.
module rlvd_core
  import rlvd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              kind,
  input  logic [BYTE_W-1:0] byte_value,
  output rlvd_push_t        push
);

  logic [BYTE_W-1:0] prev_lit_r, prev_lit_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [GIDX_W-1:0] gidx_r, gidx_nxt;
  logic              pending_r, pending_nxt;
  logic              ovf_r, ovf_nxt;

  logic [4:0]        shift_amt;
  logic [ACC_W-1:0]  group_bits;
  rlvd_result_t      run_res;
  rlvd_result_t      lit_res;

  // Shifted count group; the index is below four whenever it is used.
  assign shift_amt  = 5'(gidx_r[1:0]) * 5'(GROUP_BITS);
  assign group_bits = ACC_W'(byte_value[GROUP_BITS-1:0]) << shift_amt;

  // The two kinds of result this byte can cause.
  always_comb begin
    run_res.run_byte       = prev_lit_r;
    run_res.run_length     = LEN_W'(acc_r) + LEN_W'(RUN_BIAS);
    run_res.count_overflow = ovf_r;
    run_res.last           = 1'b0;
    lit_res.run_byte       = byte_value;
    lit_res.run_length     = LEN_W'(1);
    lit_res.count_overflow = 1'b0;
    lit_res.last           = 1'b1;
  end

  // Result selection and next state.
  always_comb begin
    prev_lit_nxt = prev_lit_r;
    acc_nxt      = acc_r;
    gidx_nxt     = gidx_r;
    pending_nxt  = pending_r;
    ovf_nxt      = ovf_r;
    push.num     = 2'd0;
    push.first   = lit_res;
    push.second  = lit_res;
    if (accept) begin
      priority if (kind == KIND_FLUSH) begin
        // End of stream: emit any pending run and start fresh.
        if (pending_r) begin
          push.num        = 2'd1;
          push.first      = run_res;
          push.first.last = 1'b1;
        end
        prev_lit_nxt = '0;
        acc_nxt      = '0;
        gidx_nxt     = '0;
        pending_nxt  = 1'b0;
        ovf_nxt      = 1'b0;
      end else if (byte_value[BYTE_W-1]) begin
        // Count group: accumulate or drop past the limit.
        if (gidx_r < GIDX_W'(GROUP_LIMIT)) begin
          acc_nxt  = acc_r | group_bits;
          gidx_nxt = gidx_r + GIDX_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        pending_nxt = 1'b1;
      end else begin
        // Literal: pending run first, then the literal itself.
        if (pending_r) begin
          push.num    = 2'd2;
          push.first  = run_res;
          push.second = lit_res;
        end else begin
          push.num   = 2'd1;
          push.first = lit_res;
        end
        prev_lit_nxt = byte_value;
        acc_nxt      = '0;
        gidx_nxt     = '0;
        pending_nxt  = 1'b0;
        ovf_nxt      = 1'b0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_lit_r <= '0;
      acc_r      <= '0;
      gidx_r     <= '0;
      pending_r  <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      prev_lit_r <= prev_lit_nxt;
      acc_r      <= acc_nxt;
      gidx_r     <= gidx_nxt;
      pending_r  <= pending_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

FILE: design/rlvd_queue.sv
// Result queue of the run-length varint decoder.
// Depends on rlvd_pkg; takes up to two results a cycle, gives one a cycle while out_ready is high.
module rlvd_queue
  import rlvd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  rlvd_push_t   push,
  output logic         has_room,
  output logic         out_valid,
  input  logic         out_ready,
  output rlvd_result_t out_data
);

  rlvd_result_t      entry_r [QDEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QPTR_W-1:0] tail_r, tail_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;
  logic [QPTR_W-1:0] tail_plus1;

  // Room for the worst case of two results from one transfer.
  assign has_room   = count_r <= QCNT_W'(QDEPTH - 2);
  assign out_valid  = count_r != '0;
  assign out_data   = entry_r[head_r];
  assign pop        = out_valid && out_ready;
  assign tail_plus1 = tail_r + QPTR_W'(1);

  // Pointer and fill count update.
  always_comb begin
    head_nxt  = pop ? head_r + QPTR_W'(1) : head_r;
    tail_nxt  = tail_r + QPTR_W'(push.num);
    count_nxt = count_r + QCNT_W'(push.num) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry writes, in result order.
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entry_r[tail_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      entry_r[tail_plus1] <= push.second;
    end
  end

endmodule

FILE: design/run_length_varint_decoder.sv
// Top level of the run-length varint decoder.
// Depends on rlvd_pkg, rlvd_if, rlvd_core and rlvd_queue.
//
//   Channel  Direction  Payload                                        Handshake
//   in_ch    sink       kind, byte_value                               valid/ready
//   out_ch   source     run_byte, run_length, count_overflow, last     valid/ready
//
// One input byte is taken per cycle while in_ch.ready is high; its results are
// written into a four-entry queue in the same cycle and can leave on the next
// one. A literal that closes a run gives two results, so the output side sets
// the sustained rate: one result per cycle from the queue head, while out_ch.ready
// is high. in_ch.ready is low while fewer than two queue entries are free.
// Reset is synchronous and active low and clears state and queue.
module run_length_varint_decoder
  import rlvd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rlvd_in_if.sink   in_ch,
  rlvd_out_if.source out_ch
);

  rlvd_push_t   push;
  rlvd_result_t head;
  logic         has_room;
  logic         accept;

  assign in_ch.ready = has_room;
  assign accept      = in_ch.valid && has_room;

  // Per-byte state update.
  rlvd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .kind       (in_ch.kind),
    .byte_value (in_ch.byte_value),
    .push       (push)
  );

  // Result buffering toward the output channel.
  rlvd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .has_room  (has_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (head)
  );

  assign out_ch.run_byte       = head.run_byte;
  assign out_ch.run_length     = head.run_length;
  assign out_ch.count_overflow = head.count_overflow;
  assign out_ch.last           = head.last;

endmodule
